>>> src/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// aescbc_pkg: shared types, tables and helpers for the AES-256 CBC codec
// Holds the S-box tables, which are built at elaboration, GF(2^8) helpers,
// status codes, register indexes, opcodes and the result record.
// ----------------------------------------------------------------------------
package aescbc_pkg;

   typedef logic [7:0] byte_table_type [256];

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_PAD  = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_TOO_LONG = 3'd3,
      ST_NO_KEY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_KEY0       = 3'd0,
      REG_KEY1       = 3'd1,
      REG_KEY2       = 3'd2,
      REG_KEY3       = 3'd3,
      REG_DIRECTION  = 3'd4,
      REG_KEY_LOADED = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [63:0] out_hi;
      logic [63:0] out_lo;
      logic [4:0]  valid_bytes;
      status_type  status;
      logic        frame_end;
   } result_type;

   // request opcodes
   localparam logic OP_IV   = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic [3:0] LAST_ROUND = 4'd14;

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] x;
      r = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x;
         x = xt(x);
      end
      return r;
   endfunction

   // x^254, maps zero to zero
   function automatic logic [7:0] ginv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      logic [7:0] e;
      r = 8'h01;
      p = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gmul(r, p);
         p = gmul(p, p);
      end
      return r;
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
      logic [15:0] d;
      d = {x, x} << n;
      return d[15:8];
   endfunction

   function automatic byte_table_type gen_sbox();
      byte_table_type t;
      logic [7:0] b;
      for (int i = 0; i < 256; i++) begin
         b = ginv(8'(i));
         t[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
      end
      return t;
   endfunction

   function automatic byte_table_type gen_inv_sbox();
      byte_table_type t;
      logic [7:0] s;
      for (int i = 0; i < 256; i++) begin
         s = 8'(i);
         t[i] = ginv(rol8(s, 1) ^ rol8(s, 3) ^ rol8(s, 6) ^ 8'h05);
      end
      return t;
   endfunction

   localparam byte_table_type SBOX     = gen_sbox();
   localparam byte_table_type INV_SBOX = gen_inv_sbox();

   localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

endpackage

>>> src/aescbc_key_sched.sv
// ----------------------------------------------------------------------------
// aescbc_key_sched: iterative AES-256 key expansion
// Produces one 32-bit key word per cycle from an eight-word window and
// stores the fifteen 128-bit round keys for the round unit.
// ----------------------------------------------------------------------------
module aescbc_key_sched
   import aescbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [255:0] key,
   input  logic [3:0]   rd_row,
   output logic [127:0] rd_key,
   output logic         busy
);

   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [5:0]   idx_ff, idx_in;
   logic         run_ff, run_in;
   logic [127:0] rk_ff [15];
   logic         wr_en;
   logic [3:0]   wr_row;
   logic [127:0] wr_data;
   logic [31:0]  t;
   logic [31:0]  new_word;

   // compute the next key word
   always_comb begin
      t = win_ff[7];
      if (idx_ff[2:0] == 3'd0) begin
         t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]}
             ^ {RCON[idx_ff[5:3] - 3'd1], 24'h0};
      end else if (idx_ff[2:0] == 3'd4) begin
         t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
      end
      new_word = win_ff[0] ^ t;
   end

   // advance the window and pick the row to store
   always_comb begin
      win_in  = win_ff;
      idx_in  = idx_ff;
      run_in  = run_ff;
      wr_en   = 1'b0;
      wr_row  = 4'd0;
      wr_data = key[255:128];
      if (start) begin
         for (int j = 0; j < 8; j++) win_in[j] = key[255 - 32*j -: 32];
         idx_in = 6'd8;
         run_in = 1'b1;
         wr_en  = 1'b1;
      end else if (run_ff) begin
         for (int j = 0; j < 7; j++) win_in[j] = win_ff[j + 1];
         win_in[7] = new_word;
         idx_in    = idx_ff + 6'd1;
         if (idx_ff == 6'd8) begin
            wr_en   = 1'b1;
            wr_row  = 4'd1;
            wr_data = {win_ff[4], win_ff[5], win_ff[6], win_ff[7]};
         end else if (idx_ff[1:0] == 2'd3) begin
            wr_en   = 1'b1;
            wr_row  = idx_ff[5:2];
            wr_data = {win_ff[5], win_ff[6], win_ff[7], new_word};
         end
         if (idx_ff == 6'd59) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      idx_ff <= idx_in;
      win_ff <= win_in;
      if (wr_en) rk_ff[wr_row] <= wr_data;
   end

   assign rd_key = rk_ff[rd_row];
   assign busy   = run_ff;

endmodule

>>> src/aescbc_round.sv
// ----------------------------------------------------------------------------
// aescbc_round: one AES round, forward or inverse
// Shift rows, byte substitution, optional column mix and round key add,
// reused for every round of both directions.
// ----------------------------------------------------------------------------
module aescbc_round
   import aescbc_pkg::*;
(
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         inverse,
   input  logic         mix_en,
   output logic [127:0] state_out
);

   localparam logic [7:0] MF [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
   localparam logic [7:0] MI [4] = '{8'd14, 8'd11, 8'd13, 8'd9};

   logic [7:0] s   [16];
   logic [7:0] k   [16];
   logic [7:0] fsb [16];
   logic [7:0] isb [16];
   logic [7:0] fmc [16];
   logic [7:0] dak [16];
   logic [7:0] imc [16];
   logic [7:0] v;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_in[127 - 8*i -: 8];
         k[i] = round_key[127 - 8*i -: 8];
      end
      // shift and substitute
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            fsb[c*4 + r] = SBOX[s[((c + r) % 4)*4 + r]];
            isb[((c + r) % 4)*4 + r] = INV_SBOX[s[c*4 + r]];
         end
      end
      for (int i = 0; i < 16; i++) dak[i] = isb[i] ^ k[i];
      // mix columns
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int j = 0; j < 4; j++) v = v ^ gmul(MF[(j - r + 4) % 4], fsb[c*4 + j]);
            fmc[c*4 + r] = v;
            v = 8'h00;
            for (int j = 0; j < 4; j++) v = v ^ gmul(MI[(j - r + 4) % 4], dak[c*4 + j]);
            imc[c*4 + r] = v;
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (inverse) begin
            state_out[127 - 8*i -: 8] = mix_en ? imc[i] : dak[i];
         end else begin
            state_out[127 - 8*i -: 8] = (mix_en ? fmc[i] : fsb[i]) ^ k[i];
         end
      end
   end

endmodule

>>> src/aes256_cbc_pkcs7_codec.sv
// ----------------------------------------------------------------------------
// aes256_cbc_pkcs7_codec: AES-256 CBC codec with PKCS#7 padding
// A sequencer drives one shared round unit for every block and a serial
// key expander at each IV, with a two-entry result queue on the output.
//
//   channel  dir  tdata (low bit up)               tuser     tlast
//   req_     in   data_hi, data_lo, byte_count     opcode    last
//   rsp_     out  out_hi, out_lo, valid_bytes      status    frame_end
//   csr_     in   write enable, index, 64-bit data
//
// A data block passes accept, decode, load, the rounds of the single round
// unit and finish, then emits its results; an extra pad block runs load,
// rounds and finish again. An IV item waits for the key expander, which
// produces one key word a cycle.
// req_tready is high only in idle; results wait in the queue under
// rsp_tready. Reset is synchronous and clears the sequencer state, key and chain.
// ----------------------------------------------------------------------------
module aes256_cbc_pkcs7_codec
   import aescbc_pkg::*;
#(
   parameter int MAX_BLOCKS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // data_hi, data_lo, byte_count, zero fill
   input  logic         req_tuser,   // opcode
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // out_hi, out_lo, valid_bytes, zero fill
   output logic [2:0]   rsp_tuser,   // status
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECIDE = 7'b0000010,
      S_KEXP   = 7'b0000100,
      S_LOAD   = 7'b0001000,
      S_CRYPT  = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   localparam logic [127:0] PAD_FULL = {16{8'h10}};

   state_type    state_ff, state_in;
   logic [255:0] key_ff, key_in;
   logic         dir_ff, dir_in;
   logic         kl_ff, kl_in;
   logic         op_ff, op_in;
   logic [127:0] data_ff, data_in;
   logic [4:0]   bc_ff, bc_in;
   logic         last_ff, last_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] s_ff, s_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] held_ff, held_in;
   logic         heldv_ff, heldv_in;
   logic [4:0]   count_ff, count_in;
   logic         open_ff, open_in;
   logic         fe_ff, fe_in;
   logic         extra_ff, extra_in;
   logic [3:0]   rnd_ff, rnd_in;
   result_type   q_ff [2];
   result_type   q_in [2];
   logic [1:0]   qn_ff, qn_in;

   logic         ks_start;
   logic         ks_busy;
   logic [3:0]   rk_base;
   logic [3:0]   rk_row;
   logic [127:0] rk;
   logic [127:0] round_out;
   logic         need2;
   logic [5:0]   enc_total;
   logic [5:0]   dec_total;
   logic [4:0]   padn;
   logic [127:0] padded;
   logic [127:0] plain;
   logic [7:0]   pad;
   logic         pad_ok;
   logic [4:0]   keep;
   logic [127:0] trimmed;
   logic         fail;
   status_type   fail_st;

   // key expander and round unit
   assign rk_base = (state_ff == S_LOAD) ? 4'd0 : rnd_ff;
   assign rk_row  = dir_ff ? (LAST_ROUND - rk_base) : rk_base;
   assign ks_start = (state_ff == S_DECIDE) && (op_ff == OP_IV) && kl_ff;

   aescbc_key_sched u_key_sched (
      .clock  (clock),
      .reset  (reset),
      .start  (ks_start),
      .key    (key_ff),
      .rd_row (rk_row),
      .rd_key (rk),
      .busy   (ks_busy)
   );

   aescbc_round u_round (
      .state_in  (s_ff),
      .round_key (rk),
      .inverse   (dir_ff),
      .mix_en    (rnd_ff != LAST_ROUND),
      .state_out (round_out)
   );

   // block preparation and pad check
   always_comb begin
      need2     = last_ff && (bc_ff == 5'd16);
      enc_total = {1'b0, count_ff} + (need2 ? 6'd2 : 6'd1);
      dec_total = {1'b0, count_ff} + 6'd1;
      padn      = 5'd16 - bc_ff;
      for (int i = 0; i < 16; i++) begin
         if (last_ff && (i >= int'(bc_ff))) padded[127 - 8*i -: 8] = {3'b000, padn};
         else padded[127 - 8*i -: 8] = data_ff[127 - 8*i -: 8];
      end
      plain  = s_ff ^ chain_ff;
      pad    = plain[7:0];
      pad_ok = (pad >= 8'd1) && (pad <= 8'd16);
      for (int i = 0; i < 16; i++) begin
         if ((i >= 16 - int'(pad)) && (plain[127 - 8*i -: 8] != pad)) pad_ok = 1'b0;
      end
      keep = 5'd16 - pad[4:0];
      for (int i = 0; i < 16; i++) begin
         trimmed[127 - 8*i -: 8] = (i >= int'(keep)) ? 8'h00 : plain[127 - 8*i -: 8];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      dir_in   = dir_ff;
      kl_in    = kl_ff;
      op_in    = op_ff;
      data_in  = data_ff;
      bc_in    = bc_ff;
      last_in  = last_ff;
      blk_in   = blk_ff;
      s_in     = s_ff;
      chain_in = chain_ff;
      held_in  = held_ff;
      heldv_in = heldv_ff;
      count_in = count_ff;
      open_in  = open_ff;
      fe_in    = fe_ff;
      extra_in = extra_ff;
      rnd_in   = rnd_ff;
      q_in     = q_ff;
      qn_in    = qn_ff;
      fail     = 1'b0;
      fail_st  = ST_OK;

      // register writes
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_KEY0:       key_in[255:192] = csr_wdata;
            REG_KEY1:       key_in[191:128] = csr_wdata;
            REG_KEY2:       key_in[127:64]  = csr_wdata;
            REG_KEY3:       key_in[63:0]    = csr_wdata;
            REG_DIRECTION:  dir_in = csr_wdata[0];
            REG_KEY_LOADED: kl_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               data_in  = {req_tdata[63:0], req_tdata[127:64]};
               bc_in    = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];
               last_in  = req_tlast;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            if (op_ff == OP_IV) begin
               heldv_in = 1'b0;
               if (!kl_ff) begin
                  fail = 1'b1; fail_st = ST_NO_KEY;
               end else begin
                  chain_in = data_ff;
                  count_in = 5'd0;
                  open_in  = 1'b1;
                  state_in = S_KEXP;
               end
            end else if (open_ff) begin
               if (!kl_ff) begin
                  fail = 1'b1; fail_st = ST_NO_KEY;
               end else if (!dir_ff) begin
                  if (enc_total > 6'(MAX_BLOCKS)) begin
                     fail = 1'b1; fail_st = ST_TOO_LONG;
                  end else begin
                     blk_in   = padded;
                     fe_in    = last_ff && !need2;
                     extra_in = need2;
                     if (last_ff) open_in = 1'b0;
                     state_in = S_LOAD;
                  end
               end else begin
                  if (dec_total > 6'(MAX_BLOCKS)) begin
                     fail = 1'b1; fail_st = ST_TOO_LONG;
                  end else begin
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_KEXP: begin
            if (!ks_busy) begin
               state_in = S_IDLE;
               if (last_ff) begin
                  open_in = 1'b0;
                  if (dir_ff) begin
                     fail = 1'b1; fail_st = ST_EMPTY;
                  end else begin
                     blk_in   = PAD_FULL;
                     fe_in    = 1'b1;
                     extra_in = 1'b0;
                     state_in = S_LOAD;
                  end
               end
            end
         end
         S_LOAD: begin
            s_in     = (dir_ff ? data_ff : (blk_ff ^ chain_ff)) ^ rk;
            rnd_in   = 4'd1;
            state_in = S_CRYPT;
         end
         S_CRYPT: begin
            s_in   = round_out;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == LAST_ROUND) state_in = S_FINISH;
         end
         S_FINISH: begin
            count_in = count_ff + 5'd1;
            if (!dir_ff) begin
               chain_in = s_ff;
               q_in[0]  = '{s_ff[127:64], s_ff[63:0], 5'd16, ST_OK, fe_ff};
               qn_in    = 2'd1;
               state_in = S_EMIT;
            end else begin
               chain_in = data_ff;
               if (!last_ff) begin
                  held_in  = plain;
                  heldv_in = 1'b1;
                  if (heldv_ff) begin
                     q_in[0]  = '{held_ff[127:64], held_ff[63:0], 5'd16, ST_OK, 1'b0};
                     qn_in    = 2'd1;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else if (!pad_ok) begin
                  fail = 1'b1; fail_st = ST_BAD_PAD;
               end else begin
                  heldv_in = 1'b0;
                  open_in  = 1'b0;
                  state_in = S_EMIT;
                  if (heldv_ff) begin
                     q_in[0] = '{held_ff[127:64], held_ff[63:0], 5'd16, ST_OK, 1'b0};
                     q_in[1] = '{trimmed[127:64], trimmed[63:0], keep, ST_OK, 1'b1};
                     qn_in   = 2'd2;
                  end else begin
                     q_in[0] = '{trimmed[127:64], trimmed[63:0], keep, ST_OK, 1'b1};
                     qn_in   = 2'd1;
                  end
               end
            end
         end
         S_EMIT: begin
            if (rsp_tready) begin
               q_in[0] = q_ff[1];
               qn_in   = qn_ff - 2'd1;
               if (qn_ff == 2'd1) begin
                  if (extra_ff) begin
                     blk_in   = PAD_FULL;
                     fe_in    = 1'b1;
                     extra_in = 1'b0;
                     state_in = S_LOAD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // error result closes the frame
      if (fail) begin
         q_in[0]  = '{64'h0, 64'h0, 5'd0, fail_st, 1'b1};
         qn_in    = 2'd1;
         open_in  = 1'b0;
         heldv_in = 1'b0;
         extra_in = 1'b0;
         state_in = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         key_ff   <= '0;
         dir_ff   <= 1'b0;
         kl_ff    <= 1'b0;
         heldv_ff <= 1'b0;
         count_ff <= 5'd0;
         open_ff  <= 1'b0;
         extra_ff <= 1'b0;
         qn_ff    <= 2'd0;
         chain_ff <= '0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         dir_ff   <= dir_in;
         kl_ff    <= kl_in;
         heldv_ff <= heldv_in;
         count_ff <= count_in;
         open_ff  <= open_in;
         extra_ff <= extra_in;
         qn_ff    <= qn_in;
         chain_ff <= chain_in;
      end
      op_ff   <= op_in;
      data_ff <= data_in;
      bc_ff   <= bc_in;
      last_ff <= last_in;
      blk_ff  <= blk_in;
      s_ff    <= s_in;
      held_ff <= held_in;
      fe_ff   <= fe_in;
      rnd_ff  <= rnd_in;
      q_ff    <= q_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tdata  = {3'b000, q_ff[0].valid_bytes, q_ff[0].out_lo, q_ff[0].out_hi};
   assign rsp_tuser  = q_ff[0].status;
   assign rsp_tlast  = q_ff[0].frame_end;

endmodule
